// ===== rtl/g1sp_pkg.sv =====
`default_nettype none

package g1sp_pkg;

  localparam int BUFFER_BITS_DEF   = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int BPV_W       = 6;
  localparam int SCALE_W     = 6;
  localparam int REF_W       = 48;
  localparam int MULT_W      = 32;
  localparam int MULT_FRAC   = 16;
  localparam int VALUE_W     = 48;
  localparam int CODE_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int TERM_W      = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = VALUE_W + CODE_W;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_VALUE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BINARY_SCALE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_VALUE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECIMAL_MULTIPLIER = 2'd3;

  localparam logic [MULT_W-1:0] MULT_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    ST_VALUE    = 2'd0,
    ST_UNDEF    = 2'd1,
    ST_UNDERRUN = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/grib1_simple_packing_unpacker_core.sv =====
`default_nettype none
// an accepted transaction that gives a result is registered in v1, v2, v3 and v4 before m_tvalid
// throughput: one transaction per cycle while m_tready holds no stage; the bit buffer updates in the accept cycle
// and the scaling runs through four further registered stages (shift, add, two
// 32x32 multiplies, round and saturate)
// reset: synchronous; clears the bit buffer, the held count, the stage valids and
// loads the registers with their reset values (multiplier 1.0)
module grib1_simple_packing_unpacker_core #(
  parameter int BUFFER_BITS   = g1sp_pkg::BUFFER_BITS_DEF,
  parameter int FRACTION_BITS = g1sp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [g1sp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [g1sp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [g1sp_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte, present, pad
  input  wire logic                               s_tuser,  // cmd
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [g1sp_pkg::M_TDATA_W-1:0]          m_tdata,  // value, raw_code
  output logic [1:0]                              m_tuser   // status
);
  import g1sp_pkg::*;

  localparam int BH_W = $clog2(BUFFER_BITS + 1);
  localparam int Q_W  = VALUE_W + 1;
  localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(1) << (VALUE_W - 1);
  localparam logic [Q_W-1:0] Q_POS_MAX = Q_NEG_MAX - Q_W'(1);

  // configuration
  logic [BPV_W-1:0]          bits_per_value;
  logic signed [SCALE_W-1:0] binary_scale;
  logic [REF_W-1:0]          reference_value;
  logic [MULT_W-1:0]         decimal_multiplier;

  // buffer state
  logic [BUFFER_BITS-1:0] bit_buffer, bit_buffer_next;
  logic [BH_W-1:0]        bits_held, bits_held_next;

  // pipeline
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  status_t st1, st2, st3, st4, st_out;
  logic [CODE_W-1:0] code1, code2, code3, code4, code_out;
  logic [TERM_W-1:0] term2, mag3;
  logic              sneg3, sneg4;
  logic [2*MULT_W-1:0] phi4, plo4;
  logic [VALUE_W-1:0]  value_out;

  // accept stage
  logic            s_fire;
  logic [BYTE_W-1:0] data_byte;
  logic            present;
  logic [BPV_W-1:0] width_eff;
  logic            push_full;
  logic [CODE_W-1:0] code_pick;
  logic [BUFFER_BITS-1:0] appended;
  logic            r_valid;
  status_t         r_status;
  logic [CODE_W-1:0] r_code;

  assign data_byte = s_tdata[BYTE_W-1:0];
  assign present   = s_tdata[BYTE_W];
  assign s_fire    = s_tvalid && s_tready;

  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy4     = !v4 || rdy_out;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  assign width_eff = (bits_per_value > BPV_W'(CODE_W)) ? BPV_W'(CODE_W) : bits_per_value;
  assign push_full = ({1'b0, bits_held} + (BH_W+1)'(BYTE_W)) > (BH_W+1)'(BUFFER_BITS);
  assign code_pick = bit_buffer[BUFFER_BITS-1 -: CODE_W] >> (BPV_W'(CODE_W) - width_eff);
  assign appended  = {data_byte, {(BUFFER_BITS-BYTE_W){1'b0}}} >> bits_held;

  always_comb begin
    bit_buffer_next = bit_buffer;
    bits_held_next  = bits_held;
    r_valid         = 1'b0;
    r_status        = ST_VALUE;
    r_code          = '0;
    if (s_fire) begin
      if (s_tuser == CMD_PUSH) begin
        if (push_full) begin
          r_valid  = 1'b1;
          r_status = ST_DROPPED;
        end else begin
          bit_buffer_next = bit_buffer | appended;
          bits_held_next  = bits_held + BH_W'(BYTE_W);
        end
      end else if (!present) begin
        r_valid  = 1'b1;
        r_status = ST_UNDEF;
      end else if ((BH_W+1)'(width_eff) > (BH_W+1)'(bits_held)) begin
        r_valid  = 1'b1;
        r_status = ST_UNDERRUN;
      end else begin
        r_valid         = 1'b1;
        r_code          = code_pick;
        bit_buffer_next = bit_buffer << width_eff;
        bits_held_next  = bits_held - BH_W'(width_eff);
      end
    end
  end

  // code times two to the k, saturating
  logic signed [7:0] k_exp;
  logic [7:0]        k_neg;
  logic [TERM_W+CODE_W-1:0] wide;
  logic [TERM_W-1:0] term_calc;

  assign k_exp = {{(8-SCALE_W){binary_scale[SCALE_W-1]}}, binary_scale} + 8'(FRACTION_BITS);
  assign k_neg = 8'(-k_exp);
  assign wide  = {{TERM_W{1'b0}}, code1} << k_exp[6:0];

  always_comb begin
    if (!k_exp[7]) begin
      term_calc = (|wide[TERM_W+CODE_W-1:TERM_W]) ? '1 : wide[TERM_W-1:0];
    end else begin
      term_calc = {{(TERM_W-CODE_W){1'b0}}, code1} >> k_neg;
    end
  end

  // reference add
  logic              ref_neg;
  logic [REF_W-1:0]  rmag;
  logic [TERM_W:0]   sum_mag;
  logic [TERM_W-1:0] mag_calc;
  logic              sneg_calc;

  assign ref_neg = reference_value[REF_W-1];
  assign rmag    = ref_neg ? (~reference_value + REF_W'(1)) : reference_value;
  assign sum_mag = {1'b0, term2} + (TERM_W+1)'(rmag);

  always_comb begin
    sneg_calc = 1'b0;
    if (!ref_neg) begin
      mag_calc = sum_mag[TERM_W] ? '1 : sum_mag[TERM_W-1:0];
    end else if (term2 >= TERM_W'(rmag)) begin
      mag_calc = term2 - TERM_W'(rmag);
    end else begin
      mag_calc  = TERM_W'(rmag) - term2;
      sneg_calc = 1'b1;
    end
  end

  // round and saturate
  logic [Q_W-1:0]     q, q_sat;
  logic [VALUE_W-1:0] value_calc;

  always_comb begin
    if (|phi4[2*MULT_W-1:MULT_W]) begin
      q = Q_NEG_MAX;
    end else begin
      q = Q_W'({phi4[MULT_W-1:0], {MULT_FRAC{1'b0}}}) + Q_W'(plo4 >> MULT_FRAC);
    end
    if (sneg4) begin
      q_sat      = (q > Q_NEG_MAX) ? Q_NEG_MAX : q;
      value_calc = ~q_sat[VALUE_W-1:0] + VALUE_W'(1);
    end else begin
      q_sat      = (q > Q_POS_MAX) ? Q_POS_MAX : q;
      value_calc = q_sat[VALUE_W-1:0];
    end
    if (st4 != ST_VALUE) begin
      value_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_value     <= '0;
      binary_scale       <= '0;
      reference_value    <= '0;
      decimal_multiplier <= MULT_RESET;
      bit_buffer         <= '0;
      bits_held          <= '0;
      v1                 <= 1'b0;
      v2                 <= 1'b0;
      v3                 <= 1'b0;
      v4                 <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BITS_PER_VALUE:     bits_per_value     <= cfg_data[BPV_W-1:0];
          CFG_BINARY_SCALE:       binary_scale       <= cfg_data[SCALE_W-1:0];
          CFG_REFERENCE_VALUE:    reference_value    <= cfg_data[REF_W-1:0];
          CFG_DECIMAL_MULTIPLIER: decimal_multiplier <= cfg_data[MULT_W-1:0];
        endcase
      end
      bit_buffer <= bit_buffer_next;
      bits_held  <= bits_held_next;
      if (rdy1) v1 <= r_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy_out) m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      st1   <= r_status;
      code1 <= r_code;
    end
    if (rdy2) begin
      st2   <= st1;
      code2 <= code1;
      term2 <= term_calc;
    end
    if (rdy3) begin
      st3   <= st2;
      code3 <= code2;
      mag3  <= mag_calc;
      sneg3 <= sneg_calc;
    end
    if (rdy4) begin
      st4   <= st3;
      code4 <= code3;
      sneg4 <= sneg3;
      phi4  <= mag3[TERM_W-1:MULT_W] * decimal_multiplier;
      plo4  <= mag3[MULT_W-1:0] * decimal_multiplier;
    end
    if (rdy_out) begin
      st_out    <= st4;
      code_out  <= code4;
      value_out <= value_calc;
    end
  end

  assign m_tdata = {code_out, value_out};
  assign m_tuser = st_out;

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    bits_held <= BH_W'(BUFFER_BITS))
    else $error("bit count beyond buffer size");

  a_push_adds: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == CMD_PUSH && !push_full |=> bits_held == $past(bits_held) + BH_W'(BYTE_W))
    else $error("accepted byte not counted");

  a_underrun_keeps: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == CMD_POINT && present &&
    (BH_W+1)'(width_eff) > (BH_W+1)'(bits_held) |=> $stable(bits_held) && $stable(bit_buffer))
    else $error("underrun consumed bits");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_VALUE |-> m_tdata == '0)
    else $error("payload not zero on error status");

endmodule

`default_nettype wire
